// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// expression that must never be true on a clock edge
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== sv/tcge_pkg.sv =====
// ---------------------------------------------------------------------------
// tcge_pkg
// types and constants shared by the glyph emitter front end, queue and back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcge_pkg;

  // operations handed from the front end to the back end
  typedef enum logic [3:0] {
    OP_NOP,
    OP_GLYPH,
    OP_KANA,
    OP_TAB,
    OP_NEWLINE,
    OP_CR,
    OP_LOCATE,
    OP_HIRA,
    OP_KATA,
    OP_GRAD_ON,
    OP_GRAD_OFF
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] code;
    logic [9:0] loc_x;
    logic [9:0] loc_y;
  } cmd_t;

  typedef struct packed {
    logic [9:0] offset_x;
    logic [9:0] offset_y;
    logic       shadow_enable;
    logic [7:0] hiragana_code;
    logic [7:0] katakana_code;
    logic [7:0] gradient_on_code;
    logic [7:0] gradient_off_code;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_OFFSET_X     = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd1;
  localparam logic [2:0] REG_SHADOW_EN    = 3'd2;
  localparam logic [2:0] REG_HIRAGANA     = 3'd3;
  localparam logic [2:0] REG_KATAKANA     = 3'd4;
  localparam logic [2:0] REG_GRADIENT_ON  = 3'd5;
  localparam logic [2:0] REG_GRADIENT_OFF = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_NORMAL   = 2'd0;
  localparam logic [1:0] KIND_GRADIENT = 2'd1;
  localparam logic [1:0] KIND_SHADOW   = 2'd2;
  localparam logic [1:0] KIND_GLYPH    = 2'd3;

  // character classes
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_KANA_LO  = 8'hA0;
  localparam logic [7:0] CH_KANA_MID = 8'hBF;
  localparam logic [7:0] CH_KANA_HI  = 8'hDF;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] KANA_SHIFT  = 8'h20;

  // cursor geometry in quarter pixels
  localparam logic [15:0] GLYPH_STEP    = 16'd32;
  localparam logic [15:0] SHADOW_OFFSET = 16'd4;

  // reset values of the registers
  localparam cfg_t CFG_RESET = '{
    offset_x:          10'd0,
    offset_y:          10'd0,
    shadow_enable:     1'b1,
    hiragana_code:     8'd139,
    katakana_code:     8'd140,
    gradient_on_code:  8'd141,
    gradient_off_code: 8'd142
  };

endpackage

// ===== sv/text_cursor_glyph_emitter_unit.sv =====
// ---------------------------------------------------------------------------
// text_cursor_glyph_emitter_unit
// first result of a byte goes through the queue, the back end dispatch and the output register
// throughput: one result per cycle while the output is not stalled; a glyph takes
//   a dispatch step plus 1 to 3 results in the back end sequencer, a tab up to 1 + 8 x 2 results
// control bytes and locate take only the dispatch step
// reset: synchronous, registers to defaults, queue empty, cursor 0, mode flag set
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_cursor_glyph_emitter_unit #(
  parameter int TAB_SPACES_MAX = 8,  // 1 to 16, spaces beyond 8 are never drawn
  parameter int QUEUE_DEPTH    = 2   // 2 or more
) (
  input  logic               clk,
  input  logic               rst_n,
  // request transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [7:0]         in_char_code,
  input  logic [9:0]         in_loc_x,
  input  logic [9:0]         in_loc_y,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_cmd_kind,
  output logic signed [15:0] out_rect_left,
  output logic signed [15:0] out_rect_top,
  output logic [8:0]         out_tile_index,
  output logic [8:0]         out_tex_s,
  output logic [12:0]        out_tex_t,
  output logic               out_last,
  // register write transactions
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  // register file, written whenever a transaction arrives at a mapped index
  tcge_pkg::cfg_t      cfg_regs_r, cfg_regs_nxt;
  tcge_pkg::q_status_t q_status;
  tcge_pkg::cmd_t      push_cmd, pop_cmd;
  logic                push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_regs_nxt = cfg_regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tcge_pkg::REG_OFFSET_X:     cfg_regs_nxt.offset_x          = cfg_data;
        tcge_pkg::REG_OFFSET_Y:     cfg_regs_nxt.offset_y          = cfg_data;
        tcge_pkg::REG_SHADOW_EN:    cfg_regs_nxt.shadow_enable     = cfg_data[0];
        tcge_pkg::REG_HIRAGANA:     cfg_regs_nxt.hiragana_code     = cfg_data[7:0];
        tcge_pkg::REG_KATAKANA:     cfg_regs_nxt.katakana_code     = cfg_data[7:0];
        tcge_pkg::REG_GRADIENT_ON:  cfg_regs_nxt.gradient_on_code  = cfg_data[7:0];
        tcge_pkg::REG_GRADIENT_OFF: cfg_regs_nxt.gradient_off_code = cfg_data[7:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= tcge_pkg::CFG_RESET;
    end else begin
      cfg_regs_r <= cfg_regs_nxt;
    end
  end

  // front end: classify each byte against the fixed classes and register codes
  tcge_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .in_loc_x     (in_loc_x),
    .in_loc_y     (in_loc_y),
    .cfg          (cfg_regs_r),
    .q_status     (q_status),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // decoupling queue, lets new bytes land while results are stalled
  tcge_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  // back end: owns cursor and modes, one result per cycle into the output register while the output is not stalled
  tcge_back #(
    .TAB_SPACES_MAX (TAB_SPACES_MAX)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_regs_r),
    .q_status       (q_status),
    .pop_cmd        (pop_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cmd_kind   (out_cmd_kind),
    .out_rect_left  (out_rect_left),
    .out_rect_top   (out_rect_top),
    .out_tile_index (out_tile_index),
    .out_tex_s      (out_tex_s),
    .out_tex_t      (out_tex_t),
    .out_last       (out_last)
  );

endmodule

// ===== sv/tcge_front.sv =====
// ---------------------------------------------------------------------------
// tcge_front
// accepts requests and classifies each byte into an operation for the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcge_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [7:0]         in_char_code,
  input  logic [9:0]         in_loc_x,
  input  logic [9:0]         in_loc_y,
  input  tcge_pkg::cfg_t     cfg,
  input  tcge_pkg::q_status_t q_status,
  output logic               push,
  output tcge_pkg::cmd_t     push_cmd
);

  tcge_pkg::op_t op;

  // first match wins, register codes come last
  always_comb begin
    if (in_req_type) begin
      op = tcge_pkg::OP_LOCATE;
    end else if (in_char_code >= tcge_pkg::CH_PRINT_LO &&
                 in_char_code <= tcge_pkg::CH_PRINT_HI) begin
      op = tcge_pkg::OP_GLYPH;
    end else if (in_char_code >= tcge_pkg::CH_KANA_LO &&
                 in_char_code <= tcge_pkg::CH_KANA_HI) begin
      op = tcge_pkg::OP_KANA;
    end else if (in_char_code == tcge_pkg::CH_NUL) begin
      op = tcge_pkg::OP_NOP;
    end else if (in_char_code == tcge_pkg::CH_LF) begin
      op = tcge_pkg::OP_NEWLINE;
    end else if (in_char_code == tcge_pkg::CH_CR) begin
      op = tcge_pkg::OP_CR;
    end else if (in_char_code == tcge_pkg::CH_TAB) begin
      op = tcge_pkg::OP_TAB;
    end else if (in_char_code == cfg.hiragana_code) begin
      op = tcge_pkg::OP_HIRA;
    end else if (in_char_code == cfg.katakana_code) begin
      op = tcge_pkg::OP_KATA;
    end else if (in_char_code == cfg.gradient_on_code) begin
      op = tcge_pkg::OP_GRAD_ON;
    end else if (in_char_code == cfg.gradient_off_code) begin
      op = tcge_pkg::OP_GRAD_OFF;
    end else begin
      op = tcge_pkg::OP_NOP;
    end
  end

  assign in_ready       = !q_status.full;
  assign push           = in_valid && !q_status.full;
  assign push_cmd.op    = op;
  assign push_cmd.code  = in_char_code;
  assign push_cmd.loc_x = in_loc_x;
  assign push_cmd.loc_y = in_loc_y;

endmodule

// ===== sv/tcge_queue.sv =====
// ---------------------------------------------------------------------------
// tcge_queue
// short command queue between the front end and the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcge_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcge_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output tcge_pkg::cmd_t      pop_cmd,
  output tcge_pkg::q_status_t q_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tcge_pkg::cmd_t  entries_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == CW'(DEPTH));
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_cmd = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/tcge_back.sv =====
// ---------------------------------------------------------------------------
// tcge_back
// carries out queued operations: cursor, modes and result sequencing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcge_back #(
  parameter int TAB_SPACES_MAX = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcge_pkg::cfg_t      cfg,
  input  tcge_pkg::q_status_t q_status,
  input  tcge_pkg::cmd_t      pop_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_cmd_kind,
  output logic signed [15:0]  out_rect_left,
  output logic signed [15:0]  out_rect_top,
  output logic [8:0]          out_tile_index,
  output logic [8:0]          out_tex_s,
  output logic [12:0]         out_tex_t,
  output logic                out_last
);

  localparam int TAB_CAP = (TAB_SPACES_MAX > 8) ? 8 : TAB_SPACES_MAX;
  localparam int NW      = $clog2(TAB_CAP + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [15:0]   cursor_x_r, cursor_x_nxt;
  logic [15:0]   cursor_y_r, cursor_y_nxt;
  logic          hira_r, hira_nxt;
  logic          grad_r, grad_nxt;
  logic          mode_chg_r, mode_chg_nxt;
  logic          tab_r, tab_nxt;
  logic          shadow_done_r, shadow_done_nxt;
  logic [NW-1:0] spaces_r, spaces_nxt;
  logic [7:0]    code_r, code_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [15:0]   left_r, left_nxt;
  logic [15:0]   top_r, top_nxt;
  logic [8:0]    tile_r, tile_nxt;
  logic [8:0]    tex_s_r, tex_s_nxt;
  logic [12:0]   tex_t_r, tex_t_nxt;
  logic          last_r, last_nxt;

  logic [15:0]   base_x, base_y;
  logic [15:0]   cursor_x_step;
  logic [15:0]   tab_dist;
  logic          more;
  logic          out_free;
  logic [7:0]    kana_code;

  assign base_x = {4'd0, cfg.offset_x, 2'b00};
  assign base_y = {4'd0, cfg.offset_y, 2'b00};
  assign cursor_x_step = cursor_x_r + tcge_pkg::GLYPH_STEP;
  assign tab_dist = cursor_x_step - base_x;
  assign more = tab_r && (tab_dist[7:0] != 8'd0) &&
                ((NW + 1)'(spaces_r) + 1'b1 < (NW + 1)'(TAB_CAP));
  assign out_free = !out_valid_r || out_ready;
  assign kana_code = (pop_cmd.code <= tcge_pkg::CH_KANA_MID) ?
                     pop_cmd.code - tcge_pkg::KANA_SHIFT :
                     pop_cmd.code + tcge_pkg::KANA_SHIFT;

  always_comb begin
    state_nxt       = state_r;
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    hira_nxt        = hira_r;
    grad_nxt        = grad_r;
    mode_chg_nxt    = mode_chg_r;
    tab_nxt         = tab_r;
    shadow_done_nxt = shadow_done_r;
    spaces_nxt      = spaces_r;
    code_nxt        = code_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    kind_nxt        = kind_r;
    left_nxt        = left_r;
    top_nxt         = top_r;
    tile_nxt        = tile_r;
    tex_s_nxt       = tex_s_r;
    tex_t_nxt       = tex_t_r;
    last_nxt        = last_r;
    pop             = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop             = 1'b1;
          tab_nxt         = 1'b0;
          shadow_done_nxt = 1'b0;
          spaces_nxt      = '0;
          code_nxt        = pop_cmd.code;
          unique case (pop_cmd.op)
            tcge_pkg::OP_GLYPH: begin
              state_nxt = ST_EMIT;
            end
            tcge_pkg::OP_KANA: begin
              code_nxt  = hira_r ? kana_code : pop_cmd.code;
              state_nxt = ST_EMIT;
            end
            tcge_pkg::OP_TAB: begin
              code_nxt  = tcge_pkg::CH_SPACE;
              tab_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end
            tcge_pkg::OP_NEWLINE: begin
              cursor_y_nxt = cursor_y_r + tcge_pkg::GLYPH_STEP;
              cursor_x_nxt = base_x;
            end
            tcge_pkg::OP_CR: begin
              cursor_x_nxt = base_x;
            end
            tcge_pkg::OP_LOCATE: begin
              cursor_x_nxt = base_x + {4'd0, pop_cmd.loc_x, 2'b00};
              cursor_y_nxt = base_y + {4'd0, pop_cmd.loc_y, 2'b00};
            end
            tcge_pkg::OP_HIRA: begin
              hira_nxt = 1'b1;
            end
            tcge_pkg::OP_KATA: begin
              hira_nxt = 1'b0;
            end
            tcge_pkg::OP_GRAD_ON: begin
              grad_nxt     = 1'b1;
              mode_chg_nxt = 1'b1;
            end
            tcge_pkg::OP_GRAD_OFF: begin
              grad_nxt     = 1'b0;
              mode_chg_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          tile_nxt      = {code_r, 1'b0};
          tex_s_nxt     = {code_r[2], 8'd0};
          tex_t_nxt     = {code_r[7:3], 8'd0};
          if (mode_chg_r) begin
            // render-mode command ahead of the first glyph after a change or after reset
            mode_chg_nxt = 1'b0;
            kind_nxt     = grad_r ? tcge_pkg::KIND_GRADIENT : tcge_pkg::KIND_NORMAL;
            left_nxt     = '0;
            top_nxt      = '0;
            tile_nxt     = '0;
            tex_s_nxt    = '0;
            tex_t_nxt    = '0;
            last_nxt     = 1'b0;
          end else if (cfg.shadow_enable && !shadow_done_r) begin
            shadow_done_nxt = 1'b1;
            kind_nxt        = tcge_pkg::KIND_SHADOW;
            left_nxt        = cursor_x_r + tcge_pkg::SHADOW_OFFSET;
            top_nxt         = cursor_y_r + tcge_pkg::SHADOW_OFFSET;
            last_nxt        = 1'b0;
          end else begin
            kind_nxt     = tcge_pkg::KIND_GLYPH;
            left_nxt     = cursor_x_r;
            top_nxt      = cursor_y_r;
            last_nxt     = !more;
            cursor_x_nxt = cursor_x_step;
            if (more) begin
              spaces_nxt      = spaces_r + 1'b1;
              shadow_done_nxt = 1'b0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      hira_r        <= 1'b0;
      grad_r        <= 1'b0;
      mode_chg_r    <= 1'b1;
      tab_r         <= 1'b0;
      shadow_done_r <= 1'b0;
      spaces_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_x_r    <= cursor_x_nxt;
      cursor_y_r    <= cursor_y_nxt;
      hira_r        <= hira_nxt;
      grad_r        <= grad_nxt;
      mode_chg_r    <= mode_chg_nxt;
      tab_r         <= tab_nxt;
      shadow_done_r <= shadow_done_nxt;
      spaces_r      <= spaces_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    code_r  <= code_nxt;
    kind_r  <= kind_nxt;
    left_r  <= left_nxt;
    top_r   <= top_nxt;
    tile_r  <= tile_nxt;
    tex_s_r <= tex_s_nxt;
    tex_t_r <= tex_t_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cmd_kind   = kind_r;
  assign out_rect_left  = $signed(left_r);
  assign out_rect_top   = $signed(top_r);
  assign out_tile_index = tile_r;
  assign out_tex_s      = tex_s_r;
  assign out_tex_t      = tex_t_r;
  assign out_last       = last_r;

endmodule

// ===== sv/tcge_checker.sv =====
// ---------------------------------------------------------------------------
// tcge_checker
// port-level checks on the glyph emitter, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcge_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_cmd_kind,
  input logic signed [15:0] out_rect_left,
  input logic signed [15:0] out_rect_top,
  input logic [8:0]         out_tile_index,
  input logic [8:0]         out_tex_s,
  input logic [12:0]        out_tex_t,
  input logic               out_last
);

  // stalled result holds its kind, left edge, tile index and last flag
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_cmd_kind) && $stable(out_rect_left) && $stable(out_tile_index) && $stable(out_last), "stalled result changed")

  // mode commands carry no geometry and never close a byte
  `ASSERT_NEVER(a_mode_clean, out_valid && (out_cmd_kind == tcge_pkg::KIND_NORMAL || out_cmd_kind == tcge_pkg::KIND_GRADIENT) && (out_last || out_rect_left != 0 || out_rect_top != 0 || out_tile_index != 0 || out_tex_s != 0 || out_tex_t != 0), "mode command with payload")

  // a shadow never ends a byte
  `ASSERT_NEVER(a_shadow_not_last, out_valid && out_cmd_kind == tcge_pkg::KIND_SHADOW && out_last, "shadow marked last")

  // a taken shadow is followed at once by its glyph, offset back by four
  `ASSERT_CLK(a_shadow_then_glyph, out_valid && out_ready && out_cmd_kind == tcge_pkg::KIND_SHADOW |=> out_valid && out_cmd_kind == tcge_pkg::KIND_GLYPH && out_rect_left == $past(out_rect_left) - 16'sd4 && out_rect_top == $past(out_rect_top) - 16'sd4 && out_tile_index == $past(out_tile_index), "shadow not followed by its glyph")

endmodule

bind text_cursor_glyph_emitter_unit tcge_checker u_tcge_checker (.*);
